@@ design/ftdt_pkg.sv @@
`timescale 1ns / 1ps

package ftdt_pkg;

	localparam int FRACTION_BITS       = 32;
	localparam int VALUE_W             = 64;
	localparam int INT_W               = VALUE_W - FRACTION_BITS;
	localparam int BCD_DIGITS          = 10;
	localparam int BCD_W               = 4 * BCD_DIGITS;
	localparam logic [3:0] MAX_FRACTION_DIGITS = 4'd10;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_PREC,
		OP_ROUND,
		OP_INIT,
		OP_DABBLE,
		OP_SIGN,
		OP_INT,
		OP_POINT,
		OP_FRAC
	} op_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_INPUT,
		C_CNT_NZ,
		C_DI_NZ,
		C_PREC_ZERO,
		C_CNT_GT1
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic emit_req;
		logic cnt_nz;
		logic cnt_gt1;
		logic di_nz;
		logic prec_zero;
	} status_t;

	localparam step_t STEP_IDLE   = 4'd0;
	localparam step_t STEP_PREC   = 4'd1;
	localparam step_t STEP_ROUND  = 4'd2;
	localparam step_t STEP_INIT   = 4'd3;
	localparam step_t STEP_DABBLE = 4'd4;
	localparam step_t STEP_SIGN   = 4'd5;
	localparam step_t STEP_INT    = 4'd6;
	localparam step_t STEP_POINT  = 4'd7;
	localparam step_t STEP_FRAC   = 4'd8;
	localparam step_t STEP_DONE   = 4'd9;

	// nearest Q32 value of 0.5 * 10^-prec; nothing is added at precision zero
	function automatic logic [31:0] half_unit(input logic [3:0] prec);
		logic [31:0] r;
		begin
			unique case (prec)
				4'd1:    r = 32'd214748365;
				4'd2:    r = 32'd21474836;
				4'd3:    r = 32'd2147484;
				4'd4:    r = 32'd214748;
				4'd5:    r = 32'd21475;
				4'd6:    r = 32'd2147;
				4'd7:    r = 32'd215;
				4'd8:    r = 32'd21;
				4'd9:    r = 32'd2;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [3:0] auto_prec(input logic [INT_W-1:0] whole);
		logic [3:0] p;
		begin
			if (whole < INT_W'(1))           p = 4'd6;
			else if (whole < INT_W'(10))     p = 4'd5;
			else if (whole < INT_W'(100))    p = 4'd4;
			else if (whole < INT_W'(1000))   p = 4'd3;
			else if (whole < INT_W'(10000))  p = 4'd2;
			else if (whole < INT_W'(100000)) p = 4'd1;
			else                             p = 4'd0;
			return p;
		end
	endfunction

endpackage

@@ design/ftdt_urom.sv @@
`timescale 1ns / 1ps

module ftdt_urom (
	input  ftdt_pkg::step_t step,
	output ftdt_pkg::ctrl_t word
);

	always_comb begin
		unique case (step)
			ftdt_pkg::STEP_IDLE:
				word = '{ftdt_pkg::OP_LOAD, ftdt_pkg::C_NO_INPUT, ftdt_pkg::STEP_IDLE};
			ftdt_pkg::STEP_PREC:
				word = '{ftdt_pkg::OP_PREC, ftdt_pkg::C_NONE, ftdt_pkg::STEP_IDLE};
			ftdt_pkg::STEP_ROUND:
				word = '{ftdt_pkg::OP_ROUND, ftdt_pkg::C_NONE, ftdt_pkg::STEP_IDLE};
			ftdt_pkg::STEP_INIT:
				word = '{ftdt_pkg::OP_INIT, ftdt_pkg::C_NONE, ftdt_pkg::STEP_IDLE};
			ftdt_pkg::STEP_DABBLE:
				word = '{ftdt_pkg::OP_DABBLE, ftdt_pkg::C_CNT_NZ, ftdt_pkg::STEP_DABBLE};
			ftdt_pkg::STEP_SIGN:
				word = '{ftdt_pkg::OP_SIGN, ftdt_pkg::C_NONE, ftdt_pkg::STEP_IDLE};
			ftdt_pkg::STEP_INT:
				word = '{ftdt_pkg::OP_INT, ftdt_pkg::C_DI_NZ, ftdt_pkg::STEP_INT};
			ftdt_pkg::STEP_POINT:
				word = '{ftdt_pkg::OP_POINT, ftdt_pkg::C_PREC_ZERO, ftdt_pkg::STEP_IDLE};
			ftdt_pkg::STEP_FRAC:
				word = '{ftdt_pkg::OP_FRAC, ftdt_pkg::C_CNT_GT1, ftdt_pkg::STEP_FRAC};
			default:
				word = '{ftdt_pkg::OP_NOP, ftdt_pkg::C_ALWAYS, ftdt_pkg::STEP_IDLE};
		endcase
	end

endmodule

@@ design/ftdt_datapath.sv @@
`timescale 1ns / 1ps

module ftdt_datapath (
	input  logic                            clk,
	input  ftdt_pkg::op_t                   op,
	input  logic                            exec,
	input  logic signed [ftdt_pkg::VALUE_W-1:0] value,
	input  logic signed [4:0]               digits_after_point,
	output ftdt_pkg::status_t               status,
	output logic [7:0]                      character,
	output logic                            last
);

	logic [ftdt_pkg::VALUE_W-1:0]       raw;
	logic [ftdt_pkg::VALUE_W-1:0]       mag_q;
	logic                               neg_q;
	logic                               auto_q;
	logic [3:0]                         prec_q;
	logic [ftdt_pkg::INT_W-1:0]         bin_q;
	logic [ftdt_pkg::BCD_W-1:0]         bcd_q;
	logic [ftdt_pkg::BCD_W-1:0]         bcd_adj;
	logic [ftdt_pkg::FRACTION_BITS-1:0] frac_q;
	logic [4:0]                         cnt_q;
	logic [3:0]                         di_q;
	logic                               started_q;
	logic [3:0]                         int_digit;
	logic [ftdt_pkg::FRACTION_BITS+3:0] prod;
	logic                               skip;

	assign raw = value;

	// add-3 correction of every BCD digit before the next shift
	always_comb begin
		for (int i = 0; i < ftdt_pkg::BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                                : bcd_q[4*i +: 4];
		end
	end

	assign int_digit = bcd_q[{di_q, 2'b00} +: 4];
	assign prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};
	// leading zeros are dropped, but the units digit always prints
	assign skip = (int_digit == 4'd0) && !started_q && (di_q != 4'd0);

	always_comb begin
		status.cnt_nz    = (cnt_q != 5'd0);
		status.cnt_gt1   = (cnt_q > 5'd1);
		status.di_nz     = (di_q != 4'd0);
		status.prec_zero = (prec_q == 4'd0);
		character        = ftdt_pkg::CHAR_POINT;
		last             = 1'b0;
		unique case (op)
			ftdt_pkg::OP_SIGN: begin
				status.emit_req = neg_q;
				character       = ftdt_pkg::CHAR_MINUS;
			end
			ftdt_pkg::OP_INT: begin
				status.emit_req = !skip;
				character       = {ftdt_pkg::CHAR_DIGIT_HI, int_digit};
				last            = (di_q == 4'd0) && (prec_q == 4'd0);
			end
			ftdt_pkg::OP_POINT: begin
				status.emit_req = (prec_q != 4'd0);
			end
			ftdt_pkg::OP_FRAC: begin
				status.emit_req = 1'b1;
				character       = {ftdt_pkg::CHAR_DIGIT_HI,
				                   prod[ftdt_pkg::FRACTION_BITS +: 4]};
				last            = (cnt_q == 5'd1);
			end
			default: begin
				status.emit_req = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			unique case (op)
				ftdt_pkg::OP_LOAD: begin
					neg_q  <= raw[ftdt_pkg::VALUE_W-1];
					mag_q  <= raw[ftdt_pkg::VALUE_W-1] ? (~raw + 64'd1) : raw;
					auto_q <= digits_after_point[4];
					if (digits_after_point[4])
						prec_q <= 4'd0;
					else if (digits_after_point[3:0] > ftdt_pkg::MAX_FRACTION_DIGITS)
						prec_q <= ftdt_pkg::MAX_FRACTION_DIGITS;
					else
						prec_q <= digits_after_point[3:0];
				end
				ftdt_pkg::OP_PREC: begin
					if (auto_q)
						prec_q <= ftdt_pkg::auto_prec(
							mag_q[ftdt_pkg::VALUE_W-1:ftdt_pkg::FRACTION_BITS]);
				end
				ftdt_pkg::OP_ROUND: begin
					mag_q <= mag_q + {32'd0, ftdt_pkg::half_unit(prec_q)};
				end
				ftdt_pkg::OP_INIT: begin
					bin_q     <= mag_q[ftdt_pkg::VALUE_W-1:ftdt_pkg::FRACTION_BITS];
					frac_q    <= mag_q[ftdt_pkg::FRACTION_BITS-1:0];
					bcd_q     <= '0;
					cnt_q     <= 5'(ftdt_pkg::INT_W - 1);
					di_q      <= 4'(ftdt_pkg::BCD_DIGITS - 1);
					started_q <= 1'b0;
				end
				ftdt_pkg::OP_DABBLE: begin
					bcd_q <= {bcd_adj[ftdt_pkg::BCD_W-2:0], bin_q[ftdt_pkg::INT_W-1]};
					bin_q <= {bin_q[ftdt_pkg::INT_W-2:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
				end
				ftdt_pkg::OP_INT: begin
					if (!skip)
						started_q <= 1'b1;
					if (di_q != 4'd0)
						di_q <= di_q - 4'd1;
				end
				ftdt_pkg::OP_POINT: begin
					cnt_q <= {1'b0, prec_q};
				end
				ftdt_pkg::OP_FRAC: begin
					frac_q <= prod[ftdt_pkg::FRACTION_BITS-1:0];
					cnt_q  <= cnt_q - 5'd1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ design/fixed_to_decimal_text_unit.sv @@
`timescale 1ns / 1ps

// Prints a signed Q31.32 number as decimal ASCII, one character per output
// request, with last set on the final character. After the load come three
// setup steps, then a 32-step binary-to-BCD loop dominates, one step for the
// sign, ten steps walk the integer digits (leading zeros cost a step each)
// and one step for the point; when a fraction is printed, there follow one
// step per fraction digit and one closing step after the fraction. A
// character that cannot be handed on holds the sequencer until the output
// register frees. A new number is taken only when the sequencer is back at
// its idle step; the output register lets it finish its tail while the last
// character still waits downstream.
module fixed_to_decimal_text_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic signed [4:0]  digits_after_point,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [63:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         character,
	output logic               last
);

	ftdt_pkg::step_t   upc_q;
	ftdt_pkg::step_t   upc_next;
	ftdt_pkg::ctrl_t   cw;
	ftdt_pkg::status_t st;
	logic signed [4:0] dap_q;
	logic              out_valid_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic [7:0]        dp_char;
	logic              dp_last;
	logic              out_free;
	logic              advance;
	logic              exec;
	logic              jump;

	ftdt_urom u_urom (
		.step (upc_q),
		.word (cw)
	);

	ftdt_datapath u_dp (
		.clk                (clk),
		.op                 (cw.op),
		.exec               (exec),
		.value              (value),
		.digits_after_point (dap_q),
		.status             (st),
		.character          (dp_char),
		.last               (dp_last)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = !st.emit_req || out_free;
	assign exec     = advance && ((cw.op != ftdt_pkg::OP_LOAD) || in_valid);
	assign in_stall = (upc_q != ftdt_pkg::STEP_IDLE);

	always_comb begin
		unique case (cw.cond)
			ftdt_pkg::C_ALWAYS:    jump = 1'b1;
			ftdt_pkg::C_NO_INPUT:  jump = !in_valid;
			ftdt_pkg::C_CNT_NZ:    jump = st.cnt_nz;
			ftdt_pkg::C_DI_NZ:     jump = st.di_nz;
			ftdt_pkg::C_PREC_ZERO: jump = st.prec_zero;
			ftdt_pkg::C_CNT_GT1:   jump = st.cnt_gt1;
			default:               jump = 1'b0;
		endcase
		if (!advance)
			upc_next = upc_q;
		else if (jump)
			upc_next = cw.target;
		else
			upc_next = upc_q + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= ftdt_pkg::STEP_IDLE;
			dap_q       <= 5'sd1;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_next;
			if (cfg_write_en)
				dap_q <= digits_after_point;
			if (st.emit_req && advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st.emit_req && advance) begin
			char_q <= dp_char;
			last_q <= dp_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

@@ design/ftdt_checker.sv @@
`timescale 1ns / 1ps

module ftdt_props (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_write_en,
	input logic signed [4:0]  digits_after_point,
	input logic               in_valid,
	input logic               in_stall,
	input logic signed [63:0] value,
	input logic               out_valid,
	input logic               out_stall,
	input logic [7:0]         character,
	input logic               last
);

	// one number at a time: the unit is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a number is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(character) && $stable(last)))
		else $error("stalled output request changed");

	// a sign or a point is always followed by a digit
	a_no_trailing_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (character == ftdt_pkg::CHAR_MINUS ||
		               character == ftdt_pkg::CHAR_POINT)) |-> !last)
		else $error("text ends on a sign or a point");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == ftdt_pkg::CHAR_MINUS ||
		               character == ftdt_pkg::CHAR_POINT ||
		               character[7:4] == ftdt_pkg::CHAR_DIGIT_HI))
		else $error("unexpected character code");

endmodule

bind fixed_to_decimal_text_unit ftdt_props u_ftdt_checker (.*);

@@ verif/ftdt_checker.sv @@
`timescale 1ns / 1ps

module ftdt_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic signed [4:0]  digits_after_point,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [63:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         character,
	input  logic               last,
	output int                 expected_left,
	output int                 mismatch_count
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	text_char_t        chars_due[$];
	logic signed [4:0] prec_setting = 5'sd1;
	int                errs = 0;

	initial begin
		expected_left  = 0;
		mismatch_count = 0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("checker: %s got %h want %h at %0t", what, got, want, $realtime);
		errs++;
	endtask

	// text of one number at the current precision setting
	function automatic void queue_number_text(input logic [63:0] raw);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] ip;
		logic [63:0] fp;
		logic [63:0] den;
		logic [31:0] whole;
		int          prec;
		int          k;
		logic [7:0]  txt[$];
		logic [7:0]  int_digits[$];
		text_char_t  tc;
		neg  = raw[63];
		mag  = neg ? (~raw + 64'd1) : raw;
		prec = prec_setting;
		if (prec > int'(ftdt_pkg::MAX_FRACTION_DIGITS))
			prec = int'(ftdt_pkg::MAX_FRACTION_DIGITS);
		if (neg)
			txt.push_back(ftdt_pkg::CHAR_MINUS);
		if (prec < 0) begin
			whole = mag[63:32];
			if (whole < 1)           prec = 6;
			else if (whole < 10)     prec = 5;
			else if (whole < 100)    prec = 4;
			else if (whole < 1000)   prec = 3;
			else if (whole < 10000)  prec = 2;
			else if (whole < 100000) prec = 1;
			else                     prec = 0;
		end
		// half a unit of the last digit, nearest Q32 value
		if (prec > 0) begin
			den = 64'd1;
			for (k = 0; k <= prec; k++)
				den = den * 64'd10;
			mag = mag + (((64'd5 << ftdt_pkg::FRACTION_BITS) + den / 64'd2) / den);
		end
		ip = mag >> ftdt_pkg::FRACTION_BITS;
		fp = {32'd0, mag[31:0]};
		if (ip == 64'd0) begin
			txt.push_back(8'h30);
		end else begin
			while (ip != 64'd0) begin
				int_digits.push_front(8'h30 + 8'(ip % 64'd10));
				ip = ip / 64'd10;
			end
			foreach (int_digits[i])
				txt.push_back(int_digits[i]);
		end
		if (prec > 0) begin
			txt.push_back(ftdt_pkg::CHAR_POINT);
			for (k = 0; k < prec; k++) begin
				fp = fp * 64'd10;
				txt.push_back(8'h30 + 8'(fp[63:32]));
				fp = {32'd0, fp[31:0]};
			end
		end
		foreach (txt[i]) begin
			tc.ch   = txt[i];
			tc.last = (i == txt.size() - 1);
			chars_due.push_back(tc);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			prec_setting = 5'sd1;
			chars_due.delete();
			expected_left <= 0;
		end else begin
			if (cfg_write_en)
				prec_setting = digits_after_point;
			if (in_valid && !in_stall)
				queue_number_text(value);
			if (out_valid && !out_stall) begin
				if (chars_due.size() == 0) begin
					report_mismatch("unexpected character", character, 8'h00);
				end else begin
					want = chars_due.pop_front();
					if (character !== want.ch)
						report_mismatch("character", character, want.ch);
					if (last !== want.last)
						report_mismatch("last flag", {7'd0, last}, {7'd0, want.last});
				end
			end
			expected_left  <= chars_due.size();
			mismatch_count <= errs;
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 80;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic signed [4:0]  digits_after_point = 5'sd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [63:0] value = 64'sd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         character;
	logic               last;

	int expected_left;
	int mismatch_count;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	fixed_to_decimal_text_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write_en       (cfg_write_en),
		.digits_after_point (digits_after_point),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.value              (value),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.character          (character),
		.last               (last)
	);

	ftdt_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write_en       (cfg_write_en),
		.digits_after_point (digits_after_point),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.value              (value),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.character          (character),
		.last               (last),
		.expected_left      (expected_left),
		.mismatch_count     (mismatch_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_number(input logic [63:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		// let the count pick up a request taken at the previous edge
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		// sequencer tail may still run after the last character
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_precision(input logic [4:0] p);
		wait_drained();
		cfg_write_en       <= 1'b1;
		digits_after_point <= p;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [63:0] signed_of(input logic [63:0] mag, input logic neg);
		return neg ? (~mag + 64'd1) : mag;
	endfunction

	function automatic logic [63:0] pick_value();
		logic [63:0] mag;
		logic [31:0] p10;
		int          k;
		logic        neg;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: mag = {$urandom, $urandom};
			1: mag = {32'($urandom_range(0, 9)), $urandom};
			2: mag = {32'($urandom_range(0, 200000)), $urandom};
			3: begin
				// just below a power of ten, where rounding carries
				p10 = 32'd1;
				k = $urandom_range(0, 9);
				repeat (k) p10 = p10 * 32'd10;
				mag = {p10 - 32'd1, 32'hFFFF_FFFF - 32'($urandom_range(0, 3000000))};
			end
			4: begin
				case ($urandom_range(0, 5))
					0: mag = 64'h7FFF_FFFF_FFFF_FFFF;
					1: mag = 64'h8000_0000_0000_0000;
					2: mag = 64'd1;
					3: mag = 64'd0;
					4: mag = 64'h0000_0001_0000_0000;
					default: mag = 64'h7FFF_FFFF_0000_0000;
				endcase
			end
			default: mag = 64'($urandom_range(0, 1 << 20));
		endcase
		if (mag[63])
			return mag;
		return signed_of(mag, neg);
	endfunction

	function automatic logic [4:0] pick_precision();
		if ($urandom_range(0, 3) == 0)
			return 5'($urandom);
		return 5'($urandom_range(0, 11) - 1);
	endfunction

	initial begin
		send_idle_pct = 15;
		recv_idle_pct <= 71;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset precision of one digit
		send_number(64'h0000_0000_0000_0000);
		send_number(64'h0000_0001_0000_0000);
		send_number(64'hFFFF_FFFF_0000_0000);
		send_number(64'h0000_0000_F5C2_8F5C);
		send_number(64'hFFFF_FFFF_FFFF_FFFF);
		send_number(64'h7FFF_FFFF_FFFF_FFFF);
		send_number(64'h8000_0000_0000_0000);
		send_number(64'h0000_000C_570A_3D71);

		// precision zero truncates
		set_precision(5'd0);
		send_number(64'h0000_0002_FD70_A3D7);
		send_number(64'hFFFF_FFFF_8000_0000);
		send_number(64'h7FFF_FFFF_FFFF_FFFF);
		send_number(64'h0001_E240_8000_0000);

		// widest text
		set_precision(5'd10);
		send_number(64'h8000_0000_0000_0000);
		send_number(64'h0000_0003_243F_6A89);
		send_number(64'hFFFF_FFFF_FFFF_FFFF);
		send_number(64'h0000_0000_0000_0001);

		// automatic precision across its magnitude steps
		set_precision(5'h1F);
		send_number(64'h0000_0000_4000_0000);
		send_number(64'h0000_0009_8000_0000);
		send_number(64'hFFFF_FF9D_0000_0000);
		send_number(64'h0000_03E7_E666_6666);
		send_number(64'h0000_270F_FD70_A3D7);
		send_number(64'h0001_869F_FD70_A3D7);
		send_number(64'h0001_86A0_0000_0000);
		send_number(64'hFFFF_FFF9_0000_0000);

		// a saturating setting and another negative setting
		set_precision(5'd15);
		send_number(64'h0000_0001_8000_0000);
		set_precision(5'h10);
		send_number(64'h0000_0000_0000_0000);

		for (int mode = 0; mode < 3; mode++) begin
			if (mode == 1) begin
				send_idle_pct = 71;
				recv_idle_pct <= 15;
			end else if (mode == 2) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			for (int i = 0; i < 42; i++) begin
				if (i % 10 == 0)
					set_precision(pick_precision());
				send_number(pick_value());
			end
		end

		wait_drained();
		if (mismatch_count == 0 && expected_left == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
design/ftdt_pkg.sv
design/ftdt_urom.sv
design/ftdt_datapath.sv
design/fixed_to_decimal_text_unit.sv
design/ftdt_checker.sv
verif/ftdt_checker.sv
verif/tb_top.sv
